@@ rtl/sadb_pkg.sv @@
// shared byte width and slot type for the byte sort and dedup block
package sadb_pkg;

    localparam int BYTE_W = 8;

    // one byte slot: a stored cell entry or a value moving down the chain
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] value;
    } t_slot;

endpackage

@@ rtl/sadb_cell.sv @@
// one compare cell of the sorting chain: keeps the smaller byte, passes the larger one on, drops a duplicate
module sadb_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  sadb_pkg::t_slot i_carry,
    output sadb_pkg::t_slot o_carry,
    input  sadb_pkg::t_slot i_next,
    output sadb_pkg::t_slot o_store
);

    sadb_pkg::t_slot r_store;
    sadb_pkg::t_slot n_store;
    sadb_pkg::t_slot r_carry;
    sadb_pkg::t_slot n_carry;

    always_comb begin
        n_store = r_store;
        n_carry = '0;
        if (i_shift) begin
            // unload: take the neighbor's entry
            n_store = i_next;
        end else if (i_carry.valid) begin
            if (!r_store.valid) begin
                n_store = i_carry;
            end else if (i_carry.value == r_store.value) begin
                // duplicate, dropped here
                n_carry = '0;
            end else if (i_carry.value < r_store.value) begin
                n_store = i_carry;
                n_carry = r_store;
            end else begin
                n_carry = i_carry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store.valid <= 1'b0;
            r_carry.valid <= 1'b0;
        end else begin
            r_store <= n_store;
            r_carry <= n_carry;
        end
    end

    assign o_store = r_store;
    assign o_carry = r_carry;

endmodule

@@ rtl/sort_and_dedup_bytes.sv @@
// top level: chain of compare cells that sorts and dedups a byte string
// drain: after the last request, the last byte travels the full chain before emission starts
// throughput: one byte request per cycle while a string is taken in
// emission: one result per cycle unless the receiver stalls, then the block takes requests again
// reset: synchronous active low, empties all cells and clears the overflow flag
module sort_and_dedup_bytes #(
    parameter int MAX_DISTINCT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [sadb_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                        i_in_last,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [sadb_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_out_last,
    output logic                        o_overflowed
);

    localparam int CNT_W = $clog2(MAX_DISTINCT + 1);

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    t_state                      r_state;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_ovf;
    logic                        r_o_valid;
    logic [sadb_pkg::BYTE_W-1:0] r_o_byte;
    logic                        r_o_last;
    logic                        r_o_ovf;

    // carry[i] enters cell i; carry[MAX_DISTINCT] is what falls off the end
    sadb_pkg::t_slot w_carry [0:MAX_DISTINCT];
    // store[i] is cell i's entry; store[MAX_DISTINCT] is a permanent empty slot
    sadb_pkg::t_slot w_store [0:MAX_DISTINCT];

    logic w_accept;
    logic w_out_free;
    logic w_emit;
    logic w_final;

    assign o_stall  = (r_state != ST_ACCEPT);
    assign w_accept = i_valid && (r_state == ST_ACCEPT);

    // zero bytes are not characters and never enter the chain
    assign w_carry[0].valid = w_accept && (i_in_byte != '0);
    assign w_carry[0].value = i_in_byte;
    assign w_store[MAX_DISTINCT] = '0;

    // output register is free when empty or being taken this cycle
    assign w_out_free = !r_o_valid || !i_stall;
    // emission moves the whole chain one cell toward cell 0
    assign w_emit     = (r_state == ST_EMIT) && w_out_free && w_store[0].valid;
    // smallest remaining entry is the final one when its neighbor is empty
    assign w_final    = !w_store[1].valid;

    for (genvar g = 0; g < MAX_DISTINCT; g++) begin : g_cell
        sadb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_emit),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .i_next  (w_store[g+1]),
            .o_store (w_store[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_ACCEPT;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // result taken by the downstream side
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            // a byte pushed past the last cell means the store overflowed
            if (w_carry[MAX_DISTINCT].valid) begin
                r_ovf <= 1'b1;
            end
            case (r_state)
                ST_ACCEPT: begin
                    if (w_accept && i_in_last) begin
                        // let the last byte travel the full chain
                        r_state <= ST_DRAIN;
                        r_cnt   <= CNT_W'(MAX_DISTINCT);
                    end
                end
                ST_DRAIN: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        if (w_store[0].valid) begin
                            r_o_valid <= 1'b1;
                            r_o_byte  <= w_store[0].value;
                            r_o_last  <= w_final;
                            r_o_ovf   <= w_final && r_ovf;
                            if (w_final) begin
                                r_state <= ST_ACCEPT;
                                r_ovf   <= 1'b0;
                            end
                        end else begin
                            // empty string: nothing to emit, just reset the flag
                            r_state <= ST_ACCEPT;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_ACCEPT;
                end
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_byte   = r_o_byte;
    assign o_out_last   = r_o_last;
    assign o_overflowed = r_o_ovf;

endmodule

@@ rtl/sadb_checker.sv @@
// port level checks for the byte sort and dedup block, bound to the top level
module sadb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [sadb_pkg::BYTE_W-1:0] i_in_byte,
    input logic                        i_in_last,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [sadb_pkg::BYTE_W-1:0] o_out_byte,
    input logic                        o_out_last,
    input logic                        o_overflowed
);

    // stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_out_last))
        else $error("stalled result changed");

    // stalled request holds its payload
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_in_byte) && $stable(i_in_last))
        else $error("stalled request changed");

    // emitted bytes are never zero
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_byte != '0))
        else $error("zero byte emitted");

    // overflow is reported only on the final result
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflowed |-> o_out_last)
        else $error("overflow flag on non-final result");

    // no new requests while a string is still being emitted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_last |-> o_stall)
        else $error("request taken during emission");

endmodule

bind sort_and_dedup_bytes sadb_checker u_sadb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_in_byte    (i_in_byte),
    .i_in_last    (i_in_last),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_byte   (o_out_byte),
    .o_out_last   (o_out_last),
    .o_overflowed (o_overflowed)
);

@@ test/testbench.sv @@
// testbench for the byte sort and dedup block: directed, capacity and random string tests
module testbench;

    localparam int BYTE_W      = sadb_pkg::BYTE_W;
    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 400000;
    // wait after the last expected result to catch any stray one
    localparam int FLUSH_WAIT  = CAPACITY + 8;

    // one emitted result as the block should produce it
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              ovf;
    } t_sorted_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [BYTE_W-1:0] i_in_byte = '0;
    logic              i_in_last = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_out_last;
    logic              o_overflowed;

    // predictor state: the ascending distinct set and its overflow flag
    logic [BYTE_W-1:0] sorted_set[$];
    logic              set_overflowed = 1'b0;
    t_sorted_result    expected_results[$];
    t_sorted_result    oldest;

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    sort_and_dedup_bytes #(
        .MAX_DISTINCT(CAPACITY)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_overflowed (o_overflowed)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // insert one accepted request into the distinct set; on last, queue the
    // whole set in ascending order and empty it
    task automatic predict_request(input logic [BYTE_W-1:0] b, input logic last);
        int pos;
        int k;
        t_sorted_result r;
        if (b != '0) begin
            pos = 0;
            while (pos < sorted_set.size() && sorted_set[pos] < b) pos++;
            if (!(pos < sorted_set.size() && sorted_set[pos] == b)) begin
                if (pos >= CAPACITY) begin
                    // larger than everything in a full set: dropped
                    set_overflowed = 1'b1;
                end else begin
                    if (sorted_set.size() >= CAPACITY) begin
                        set_overflowed = 1'b1;
                        void'(sorted_set.pop_back());
                    end
                    sorted_set.insert(pos, b);
                end
            end
        end
        if (last) begin
            for (k = 0; k < sorted_set.size(); k++) begin
                r.value = sorted_set[k];
                r.last  = (k == sorted_set.size() - 1);
                r.ovf   = r.last && set_overflowed;
                expected_results.push_back(r);
            end
            sorted_set.delete();
            set_overflowed = 1'b0;
        end
    endtask

    // present one request, with random sender gaps ahead of it, and hold it
    // until the block takes it
    task automatic send_request(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(b, last);
    endtask

    // every accepted result is matched against the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got byte %h last %b ovf %b",
                         $time, o_out_byte, o_out_last, o_overflowed);
                error_count++;
            end else begin
                oldest = expected_results.pop_front();
                if (o_out_byte !== oldest.value) begin
                    $display("%0t: out_byte expected %h got %h",
                             $time, oldest.value, o_out_byte);
                    error_count++;
                end
                if (o_out_last !== oldest.last) begin
                    $display("%0t: out_last expected %b got %b",
                             $time, oldest.last, o_out_last);
                    error_count++;
                end
                if (o_overflowed !== oldest.ovf) begin
                    $display("%0t: overflowed expected %b got %b",
                             $time, oldest.ovf, o_overflowed);
                    error_count++;
                end
            end
        end
    end

    // extremes, repeats and the zero byte in all its positions
    task automatic test_directed_cases();
        // single extreme bytes
        send_request(8'hFF, 1'b1);
        send_request(8'h01, 1'b1);
        // alternating bit patterns, a repeat, both ends of the range
        send_request(8'hAA, 1'b0);
        send_request(8'h55, 1'b0);
        send_request(8'hAA, 1'b0);
        send_request(8'h80, 1'b0);
        send_request(8'h01, 1'b0);
        send_request(8'hFF, 1'b1);
        // zero byte mid-string is skipped
        send_request(8'h30, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h20, 1'b1);
        // zero byte carrying last closes the string with what is stored
        send_request(8'h41, 1'b0);
        send_request(8'h42, 1'b0);
        send_request(8'h00, 1'b1);
        // last on an empty set gives nothing
        send_request(8'h00, 1'b1);
        // the same byte over and over
        send_request(8'h07, 1'b0);
        send_request(8'h07, 1'b0);
        send_request(8'h07, 1'b1);
    endtask

    // more distinct bytes than the set holds
    task automatic test_capacity_overflow();
        logic [BYTE_W-1:0] pool[255];
        logic [BYTE_W-1:0] tmp;
        int k;
        int j;
        // ascending: the last byte is larger than a full set and gets dropped
        for (k = 1; k <= CAPACITY + 1; k++) begin
            send_request(k[BYTE_W-1:0], k == CAPACITY + 1);
        end
        // shuffled distinct bytes with a few repeats mixed in
        for (k = 0; k < 255; k++) pool[k] = BYTE_W'(k + 1);
        for (k = 254; k > 0; k--) begin
            j = $urandom_range(k);
            tmp = pool[k];
            pool[k] = pool[j];
            pool[j] = tmp;
        end
        for (k = 0; k < CAPACITY + 6; k++) begin
            if (k % 9 == 8) send_request(pool[$urandom_range(k - 1)], 1'b0);
            else send_request(pool[k], k == CAPACITY + 5);
        end
    endtask

    // random strings; most are well formed, some carry zero bytes or end on one
    task automatic test_random_strings(input int item_budget);
        int sent;
        int len;
        int mode;
        int k;
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] b;
        logic last;
        sent = 0;
        while (sent < item_budget) begin
            mode = $urandom_range(9);
            len  = ($urandom_range(19) == 0) ? $urandom_range(60, 80)
                                             : $urandom_range(1, 24);
            base = BYTE_W'($urandom_range(1, 247));
            for (k = 0; k < len; k++) begin
                last = (k == len - 1);
                if (mode >= 5 && mode <= 7) begin
                    // narrow alphabet, lots of repeats
                    b = base + BYTE_W'($urandom_range(7));
                end else if (mode == 8 && $urandom_range(3) == 0) begin
                    b = '0;
                end else if (mode == 9 && last) begin
                    b = '0;
                end else begin
                    b = BYTE_W'($urandom_range(1, 255));
                end
                send_request(b, last);
                if (b != '0 || last) sent++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 21;
        recv_idle_pct = 55;
        test_directed_cases();
        test_capacity_overflow();
        test_random_strings(60);

        // the other way round
        send_idle_pct = 55;
        recv_idle_pct = 21;
        test_random_strings(60);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_strings(60);

        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        // catch any stray result after the last string
        repeat (FLUSH_WAIT) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
